[rtl/core/vrrq_pkg.sv]
// vrrq_pkg: shared types and constants for the variable record ring queue
// no dependencies
`timescale 1ns / 1ps
package vrrq_pkg;
    localparam int HDR_BYTES = 4;
    localparam logic [7:0] PAD_BYTE = 8'hFF;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_NOROOM = 2'd2,
        ST_BADLEN = 2'd3
    } t_status;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_opcode;

    typedef struct packed {
        logic       op;
        logic [6:0] plen;
        logic [7:0] data;
        logic       last;
    } t_word;
endpackage

[rtl/core/vrrq_ram.sv]
// vrrq_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
`timescale 1ns / 1ps
module vrrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/core/vrrq_front.sv]
// vrrq_front: input word queue between command port and the sequencer
// depends on vrrq_pkg
`timescale 1ns / 1ps
module vrrq_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  vrrq_pkg::t_word i_word,
    output logic            o_busy,
    input  logic            i_pop,
    output logic            o_valid,
    output vrrq_pkg::t_word o_word
);
    import vrrq_pkg::*;

    t_word      r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic       w_push;

    assign o_busy  = (r_cnt == 2'd2);
    assign w_push  = i_start && !o_busy;
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (i_pop && o_valid) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop && o_valid};
        end
        if (w_push) r_q[r_wr] <= i_word;
    end
endmodule

[rtl/core/vrrq_back.sv]
// vrrq_back: ring sequencer for push bytes and pop runs
// depends on vrrq_pkg and vrrq_ram
`timescale 1ns / 1ps
module vrrq_back #(
    parameter int RING_BYTES = 4096,
    parameter int MAX_PAYLOAD_BYTES = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [6:0]      i_max_payload,
    input  logic            i_valid,
    input  vrrq_pkg::t_word i_word,
    output logic            o_take,
    output logic            o_strobe,
    output logic [7:0]      o_out_byte,
    output logic [6:0]      o_record_len,
    output logic [1:0]      o_status,
    output logic            o_last
);
    import vrrq_pkg::*;

    localparam int AW = $clog2(RING_BYTES);
    localparam int PW = AW + 1;
    localparam logic [PW-1:0] RING = PW'(RING_BYTES);
    localparam logic [PW-1:0] HDR = PW'(HDR_BYTES);
    localparam logic [6:0] MAXP = 7'(MAX_PAYLOAD_BYTES);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PAD   = 9'b000000010,
        S_HDRW  = 9'b000000100,
        S_PH0   = 9'b000001000,
        S_PH1   = 9'b000010000,
        S_PCHK  = 9'b000100000,
        S_PLD0  = 9'b001000000,
        S_PLD   = 9'b010000000,
        S_CHK2  = 9'b100000000
    } t_state;

    t_state        r_st;
    logic [PW-1:0] r_rp, r_wp, r_fp;
    logic          r_inrec;
    logic [1:0]    r_verdict;
    logic [6:0]    r_plen;
    logic [1:0]    r_k;
    logic [31:0]   r_hdr;
    logic [PW-1:0] r_ptr;
    logic [6:0]    r_len, r_cnt;
    logic [31:0]   r_wval;
    logic [PW-1:0] r_wbase;
    logic          r_wpad;
    logic          r_fin;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [7:0]    w_wdata, w_rdata;
    logic [6:0]    w_eff;
    logic [PW-1:0] w_room, w_elem;
    logic [PW+1:0] w_gapreq;
    logic          w_gap;
    logic [PW-1:0] w_count;
    logic [1:0]    w_vd;
    logic          w_wrap;
    logic [31:0]   w_hdrn;

    vrrq_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    assign w_eff  = (i_max_payload > MAXP) ? MAXP : i_max_payload;
    assign w_room = RING - r_wp;
    assign w_elem = PW'(i_word.plen) + HDR;
    assign w_count = r_fp - (r_wp + HDR);
    assign w_hdrn = {w_rdata, r_hdr[31:8]};

    always_comb begin
        w_vd = ST_OK;
        w_wrap = 1'b0;
        if (i_word.plen == 7'd0 || i_word.plen > w_eff) w_vd = ST_BADLEN;
        else if (w_room >= w_elem) w_vd = ST_OK;
        else if (r_rp != '0 && r_rp <= r_wp) w_wrap = 1'b1;
        else w_vd = ST_NOROOM;
    end

    // gap check against the read pointer, performed in S_PAD once any pad marker is written
    assign w_gapreq = {2'b0, r_wp} + {2'b0, PW'(r_plen)} + {2'b0, HDR}
                    + {2'b0, PW'(w_eff)} + {2'b0, HDR};
    assign w_gap = (r_rp <= r_wp) || ({2'b0, r_rp} >= w_gapreq);

    assign o_take = (r_st == S_IDLE) && i_valid;

    always_comb begin
        w_we = 1'b0;
        w_waddr = r_ptr[AW-1:0];
        w_wdata = i_word.data;
        w_raddr = r_ptr[AW-1:0];
        case (r_st)
            S_IDLE: begin
                w_we = o_take && i_word.op == OP_PUSH && r_inrec
                    && r_verdict == ST_OK && w_count < PW'(r_plen) && r_fp < RING;
                w_waddr = r_fp[AW-1:0];
            end
            S_PAD: begin
                w_we = r_wpad;
                w_waddr = AW'(r_wbase + PW'(r_k));
                w_wdata = r_wval[8*r_k +: 8];
            end
            S_HDRW: begin
                w_we = r_wpad || r_verdict == ST_OK;
                w_waddr = AW'(r_wbase + PW'(r_k));
                w_wdata = r_wval[8*r_k +: 8];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_strobe <= 1'b0;
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_rp <= '0;
            r_wp <= '0;
            r_fp <= '0;
            r_inrec <= 1'b0;
            r_verdict <= ST_OK;
            r_plen <= '0;
            r_fin <= 1'b0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (o_take) begin
                        if (i_word.op == OP_POP) begin
                            if (r_rp == r_wp) begin
                                o_strobe <= 1'b1;
                                o_out_byte <= '0; o_record_len <= '0;
                                o_status <= ST_EMPTY; o_last <= 1'b1;
                            end else if (r_rp >= r_wp && RING - r_rp < HDR) begin
                                r_rp <= '0; r_ptr <= '0;
                                r_st <= S_CHK2;
                            end else begin
                                r_ptr <= r_rp;
                                r_k <= '0;
                                r_st <= S_PH0;
                            end
                        end else if (!r_inrec) begin
                            r_inrec <= 1'b1;
                            r_plen <= i_word.plen;
                            r_fin <= i_word.last;
                            r_verdict <= w_vd;
                            r_fp <= r_wp + HDR;
                            if (w_vd == ST_BADLEN) begin
                                if (i_word.last) r_st <= S_HDRW;
                                r_k <= 2'd3; r_wpad <= 1'b0;
                            end else begin
                                // first byte held in r_hdr until the pad marker is out
                                r_wpad <= w_wrap && w_room >= HDR;
                                r_wbase <= r_wp;
                                r_wval <= 32'hFFFFFFFF;
                                r_hdr <= {24'd0, i_word.data};
                                r_k <= '0;
                                if (w_wrap) r_wp <= '0;
                                r_st <= S_PAD;
                            end
                        end else begin
                            if (r_verdict == ST_OK && w_count < PW'(r_plen))
                                r_fp <= r_fp + 1'b1;
                            if (i_word.last) begin
                                r_inrec <= 1'b0;
                                o_strobe <= 1'b1;
                                o_out_byte <= '0; o_record_len <= '0;
                                o_status <= r_verdict; o_last <= 1'b1;
                                if (r_verdict == ST_OK) begin
                                    r_wbase <= r_wp;
                                    r_wval <= 32'(w_count + PW'(w_count < PW'(r_plen)) + HDR);
                                    r_wp <= r_wp + w_count + PW'(w_count < PW'(r_plen)) + HDR;
                                    r_wpad <= 1'b1;
                                    r_k <= '0;
                                    r_st <= S_HDRW;
                                end
                            end
                        end
                    end
                end
                S_PAD: begin
                    // pad marker if needed, then gap check and first byte
                    if (r_wpad && r_k != 2'd3) r_k <= r_k + 1'b1;
                    else begin
                        if (!w_gap || r_verdict == ST_NOROOM) begin
                            r_fp <= r_wp + HDR;
                            r_verdict <= ST_NOROOM;
                            if (r_fin) begin
                                r_inrec <= 1'b0;
                                o_strobe <= 1'b1;
                                o_out_byte <= '0; o_record_len <= '0;
                                o_status <= ST_NOROOM; o_last <= 1'b1;
                            end
                            r_st <= S_IDLE;
                        end else begin
                            r_verdict <= ST_OK;
                            r_wbase <= r_wp + HDR;
                            r_wval <= {24'd0, r_hdr[7:0]};
                            r_fp <= r_wp + HDR + 1'b1;
                            r_wpad <= 1'b0;
                            r_k <= '0;
                            r_st <= S_HDRW;
                        end
                    end
                end
                S_HDRW: begin
                    // writes header (r_wpad) or single byte; byte case may finish record
                    if (r_wpad && r_k != 2'd3) r_k <= r_k + 1'b1;
                    else if (!r_wpad && r_verdict == ST_OK && r_fin && r_inrec) begin
                        r_inrec <= 1'b0;
                        o_strobe <= 1'b1;
                        o_out_byte <= '0; o_record_len <= '0;
                        o_status <= ST_OK; o_last <= 1'b1;
                        r_wbase <= r_wp;
                        r_wval <= 32'(HDR + 1'b1);
                        r_wp <= r_wp + HDR + 1'b1;
                        r_wpad <= 1'b1;
                        r_k <= '0;
                    end else if (!r_wpad && r_verdict == ST_BADLEN && r_inrec) begin
                        r_inrec <= 1'b0;
                        o_strobe <= 1'b1;
                        o_out_byte <= '0; o_record_len <= '0;
                        o_status <= ST_BADLEN; o_last <= 1'b1;
                        r_st <= S_IDLE;
                    end else r_st <= S_IDLE;
                end
                S_CHK2: begin
                    if (r_rp == r_wp) begin
                        o_strobe <= 1'b1;
                        o_out_byte <= '0; o_record_len <= '0;
                        o_status <= ST_EMPTY; o_last <= 1'b1;
                        r_st <= S_IDLE;
                    end else begin
                        r_k <= '0;
                        r_st <= S_PH0;
                    end
                end
                S_PH0: begin
                    r_ptr <= r_ptr + 1'b1;
                    r_st <= S_PH1;
                end
                S_PH1: begin
                    r_hdr <= w_hdrn;
                    if (r_k == 2'd3) r_st <= S_PCHK;
                    else begin
                        r_k <= r_k + 1'b1;
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_PCHK: begin
                    if (r_rp >= r_wp && r_hdr == 32'hFFFFFFFF) begin
                        r_rp <= '0; r_ptr <= '0;
                        r_st <= S_CHK2;
                    end else if (r_hdr < 32'(HDR) + 32'd1
                              || r_hdr > 32'(MAXP) + 32'(HDR)) begin
                        r_rp <= r_wp;
                        o_strobe <= 1'b1;
                        o_out_byte <= '0; o_record_len <= '0;
                        o_status <= ST_BADLEN; o_last <= 1'b1;
                        r_st <= S_IDLE;
                    end else if (r_hdr[6:0] - 7'(HDR) > w_eff) begin
                        r_rp <= r_rp + PW'(r_hdr[6:0]);
                        o_strobe <= 1'b1;
                        o_out_byte <= '0; o_record_len <= '0;
                        o_status <= ST_BADLEN; o_last <= 1'b1;
                        r_st <= S_IDLE;
                    end else begin
                        r_len <= r_hdr[6:0] - 7'(HDR);
                        r_cnt <= '0;
                        r_ptr <= r_rp + HDR;
                        r_st <= S_PLD0;
                    end
                end
                S_PLD0: begin
                    r_ptr <= r_ptr + 1'b1;
                    r_st <= S_PLD;
                end
                S_PLD: begin
                    o_strobe <= 1'b1;
                    o_out_byte <= w_rdata;
                    o_record_len <= r_len;
                    o_status <= ST_OK;
                    o_last <= (r_cnt + 7'd1 == r_len);
                    r_cnt <= r_cnt + 7'd1;
                    r_ptr <= r_ptr + 1'b1;
                    if (r_cnt + 7'd1 == r_len) begin
                        r_rp <= r_rp + PW'(r_len) + HDR;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/core/variable_record_ring_queue.sv]
// variable_record_ring_queue: top level, command queue in front of ring sequencer
// depends on vrrq_pkg, vrrq_front, vrrq_back, vrrq_ram
// push result on the last word; a first word of good length goes via S_PAD (pad, gap check)
// pop: header via S_PH0, S_PH1, S_PCHK (S_CHK2 on a wrap), then one payload byte a cycle
// a push word holds the sequencer while header and pad bytes are written one at a time
// reset: synchronous active low, pointers cleared, max_payload 64; receiver cannot stall
`timescale 1ns / 1ps
module variable_record_ring_queue #(
    parameter int RING_BYTES = 4096,
    parameter int MAX_PAYLOAD_BYTES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_data,
    input  logic       i_opcode,
    input  logic [6:0] i_payload_len,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_strobe,
    output logic [7:0] o_out_byte,
    output logic [6:0] o_record_len,
    output logic [1:0] o_status,
    output logic       o_last
);
    import vrrq_pkg::*;

    logic [6:0] r_max_payload;
    t_word      w_in, w_q;
    logic       w_valid, w_take;

    assign w_in = '{op: i_opcode, plen: i_payload_len, data: i_data_byte, last: i_last_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max_payload <= 7'd64;
        else if (i_cfg_we) r_max_payload <= i_cfg_data;
    end

    vrrq_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_word(w_in),
        .o_busy(busy), .i_pop(w_take), .o_valid(w_valid), .o_word(w_q)
    );

    vrrq_back #(.RING_BYTES(RING_BYTES), .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_max_payload(r_max_payload),
        .i_valid(w_valid), .i_word(w_q), .o_take(w_take), .o_strobe(o_strobe),
        .o_out_byte(o_out_byte), .o_record_len(o_record_len), .o_status(o_status),
        .o_last(o_last)
    );
endmodule

[tb/sv/variable_record_ring_queue_tb.sv]
// variable_record_ring_queue_tb: self-checking bench for the variable record ring queue
// streams push words and pops through the start/busy port, predicts every strobed result
// depends on vrrq_pkg and variable_record_ring_queue
`timescale 1ns / 1ps
module variable_record_ring_queue_tb;
    import vrrq_pkg::*;

    localparam int RING = 4096;
    localparam int MAXP = 64;
    localparam int SETTLE = 20;

    typedef struct {
        logic [7:0] byte_val;
        logic [6:0] rec_len;
        t_status    st;
        logic       last;
    } t_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic       i_cfg_we = 1'b0;
    logic [6:0] i_cfg_data = 7'd0;
    logic       i_opcode = 1'b0;
    logic [6:0] i_payload_len = 7'd0;
    logic [7:0] i_data_byte = 8'd0;
    logic       i_last_byte = 1'b0;
    logic       o_strobe;
    logic [7:0] o_out_byte;
    logic [6:0] o_record_len;
    logic [1:0] o_status;
    logic       o_last;

    t_word      word_q[$];
    t_result    result_q[$];
    logic [7:0] ring_mem [0:RING-1];
    int         head_pos, wr_pos, fill_pos, hold_len, max_cfg, idle_pct;
    bit         in_rec, failed;
    t_status    verdict;

    variable_record_ring_queue u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_opcode(i_opcode), .i_payload_len(i_payload_len),
        .i_data_byte(i_data_byte), .i_last_byte(i_last_byte),
        .o_strobe(o_strobe), .o_out_byte(o_out_byte), .o_record_len(o_record_len),
        .o_status(o_status), .o_last(o_last)
    );

    always #1 i_clk = ~i_clk;

    function automatic int eff_max();
        return (max_cfg > MAXP) ? MAXP : max_cfg;
    endfunction

    function automatic logic [7:0] ring_rd(int pos);
        return (pos < RING) ? ring_mem[pos] : 8'd0;
    endfunction

    function automatic logic [31:0] ring_rd32(int pos);
        return {ring_rd(pos + 3), ring_rd(pos + 2), ring_rd(pos + 1), ring_rd(pos)};
    endfunction

    function automatic void ring_wr32(int pos, logic [31:0] v);
        for (int i = 0; i < 4; i++) begin
            if (pos + i < RING) ring_mem[pos + i] = v[8*i +: 8];
        end
    endfunction

    function automatic void add_result(logic [7:0] b, int len, t_status st, logic lst);
        t_result r;
        r.byte_val = b;
        r.rec_len = len[6:0];
        r.st = st;
        r.last = lst;
        result_q.push_back(r);
    endfunction

    function automatic bit room_ahead(int elem);
        return head_pos <= wr_pos || head_pos >= wr_pos + elem + eff_max() + HDR_BYTES;
    endfunction

    function automatic t_status judge_push(int len);
        int elem, room;
        if (len == 0 || len > eff_max()) return ST_BADLEN;
        elem = len + HDR_BYTES;
        room = RING - wr_pos;
        if (room >= elem) return room_ahead(elem) ? ST_OK : ST_NOROOM;
        if (head_pos > 0 && head_pos <= wr_pos) begin
            if (room >= HDR_BYTES) ring_wr32(wr_pos, 32'hFFFF_FFFF);
            wr_pos = 0;
            return room_ahead(elem) ? ST_OK : ST_NOROOM;
        end
        return ST_NOROOM;
    endfunction

    function automatic void pop_record();
        int hdr, len;
        if (head_pos == wr_pos) begin
            add_result(8'd0, 0, ST_EMPTY, 1'b1);
            return;
        end
        if (head_pos >= wr_pos &&
            (RING - head_pos < HDR_BYTES || ring_rd32(head_pos) == 32'hFFFF_FFFF))
            head_pos = 0;
        if (head_pos == wr_pos) begin
            add_result(8'd0, 0, ST_EMPTY, 1'b1);
            return;
        end
        hdr = int'(ring_rd32(head_pos));
        if (hdr < HDR_BYTES + 1 || hdr > MAXP + HDR_BYTES) begin
            head_pos = wr_pos;
            add_result(8'd0, 0, ST_BADLEN, 1'b1);
            return;
        end
        len = hdr - HDR_BYTES;
        if (len > eff_max()) begin
            head_pos += hdr;
            add_result(8'd0, 0, ST_BADLEN, 1'b1);
            return;
        end
        for (int i = 0; i < len; i++)
            add_result(ring_rd(head_pos + HDR_BYTES + i), len, ST_OK, i == len - 1);
        head_pos += hdr;
    endfunction

    function automatic void apply_word(t_word w);
        int count;
        if (w.op == OP_POP) begin
            pop_record();
            return;
        end
        if (!in_rec) begin
            in_rec = 1'b1;
            hold_len = w.plen;
            verdict = judge_push(w.plen);
            fill_pos = wr_pos + HDR_BYTES;
        end
        count = fill_pos - (wr_pos + HDR_BYTES);
        if (verdict == ST_OK && count < hold_len) begin
            if (fill_pos < RING) ring_mem[fill_pos] = w.data;
            fill_pos++;
            count++;
        end
        if (!w.last) return;
        if (verdict == ST_OK) begin
            ring_wr32(wr_pos, 32'(count + HDR_BYTES));
            wr_pos += count + HDR_BYTES;
        end
        in_rec = 1'b0;
        add_result(8'd0, 0, verdict, 1'b1);
    endfunction

    // driver: holds a word until accepted, random gaps between words
    always @(posedge i_clk) begin
        bit acc;
        t_word w;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            acc = start && !busy;
            if (acc) apply_word(word_q.pop_front());
            if (acc || !start) begin
                if (word_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    w = word_q[0];
                    start <= 1'b1;
                    i_opcode <= w.op;
                    i_payload_len <= w.plen;
                    i_data_byte <= w.data;
                    i_last_byte <= w.last;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && o_strobe) begin
            if (result_q.size() == 0) begin
                $display("%0t unexpected result byte %h len %0d status %0d last %b",
                    $realtime, o_out_byte, o_record_len, o_status, o_last);
                failed = 1'b1;
            end else begin
                r = result_q.pop_front();
                if (o_out_byte !== r.byte_val) begin
                    $display("%0t out_byte expected %h actual %h", $realtime, r.byte_val,
                        o_out_byte);
                    failed = 1'b1;
                end
                if (o_record_len !== r.rec_len) begin
                    $display("%0t record_len expected %0d actual %0d", $realtime, r.rec_len,
                        o_record_len);
                    failed = 1'b1;
                end
                if (o_status !== r.st) begin
                    $display("%0t status expected %0d actual %0d", $realtime, r.st, o_status);
                    failed = 1'b1;
                end
                if (o_last !== r.last) begin
                    $display("%0t last expected %b actual %b", $realtime, r.last, o_last);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic push_word(t_opcode op, int len, logic [7:0] d, logic lst);
        t_word w;
        w.op = op;
        w.plen = len[6:0];
        w.data = d;
        w.last = lst;
        word_q.push_back(w);
    endtask

    task automatic add_pop();
        push_word(OP_POP, $urandom_range(127), 8'($urandom_range(255)),
            1'($urandom_range(1)));
    endtask

    // bytes after the first carry a random length, which the block ignores
    task automatic add_record(int len, int nbytes);
        for (int i = 0; i < nbytes; i++)
            push_word(OP_PUSH, i == 0 ? len : $urandom_range(127),
                8'($urandom_range(255)), i == nbytes - 1);
    endtask

    task automatic wait_idle();
        while (word_q.size() != 0 || start || result_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_max(int v);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v[6:0];
        max_cfg = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int nwords, int cfg, int pct);
        int r, len, nb, emax, lim, added;
        set_max(cfg);
        idle_pct = pct;
        emax = (cfg > MAXP) ? MAXP : cfg;
        lim = (emax > 16) ? 16 : emax;
        added = 0;
        while (added < nwords) begin
            r = $urandom_range(99);
            if (r < 40) begin
                add_pop();
                added++;
            end else begin
                len = (r < 48) ? $urandom_range(127) : $urandom_range(1, lim);
                if (len == 0 || len > emax) nb = $urandom_range(1, 3);
                else nb = ($urandom_range(9) == 0) ? $urandom_range(1, len + 3) : len;
                if ($urandom_range(19) == 0 && nb > 1) begin
                    // pop in the middle of a record
                    push_word(OP_PUSH, len, 8'($urandom_range(255)), 1'b0);
                    add_pop();
                    for (int i = 1; i < nb; i++)
                        push_word(OP_PUSH, $urandom_range(127), 8'($urandom_range(255)),
                            i == nb - 1);
                    added += nb + 1;
                end else begin
                    add_record(len, nb);
                    added += nb;
                end
            end
        end
    endtask

    initial begin
        for (int i = 0; i < RING; i++) ring_mem[i] = 8'd0;
        head_pos = 0;
        wr_pos = 0;
        fill_pos = 0;
        hold_len = 0;
        in_rec = 1'b0;
        verdict = ST_OK;
        max_cfg = MAXP;
        failed = 1'b0;
        idle_pct = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_max(64);
        add_pop();
        add_record(1, 1);
        add_record(64, 64);
        add_pop();
        add_pop();
        add_record(0, 1);
        add_record(127, 2);
        add_record(5, 2);
        add_record(3, 5);
        add_record(2, 1);
        add_pop();
        add_record(10, 10);
        add_pop();
        add_pop();
        add_record(10, 10);

        // stored record longer than the new maximum
        random_phase(50, 1, 37);
        random_phase(50, 127, 75);
        random_phase(50, 45, 0);

        wait_idle();
        if (failed)
            $display("variable_record_ring_queue_tb NOT OK");
        else
            $display("variable_record_ring_queue_tb OK");
        $finish;
    end

    initial begin
        #2000000;
        $display("variable_record_ring_queue_tb NOT OK");
        $finish;
    end
endmodule

[files.f]
rtl/core/vrrq_pkg.sv
rtl/core/vrrq_ram.sv
rtl/core/vrrq_front.sv
rtl/core/vrrq_back.sv
rtl/core/variable_record_ring_queue.sv
tb/sv/variable_record_ring_queue_tb.sv
